@@ sv/hsvrgb_pkg.sv @@
// ============================================================================
// hsvrgb_pkg
// Shared types, widths and constants of the HSV to RGB color unit.
// ============================================================================
`default_nettype none

package hsvrgb_pkg;

    // Channel width and derived widths
    localparam int CHANNEL_BITS = 8;
    localparam int HUE_W        = 9;
    localparam int PROD_W       = 2 * CHANNEL_BITS;
    localparam int FRAC_W       = 6;
    localparam int SECT_W       = 3;

    // Full scale of one channel and its rounding half
    localparam int FULL      = (1 << CHANNEL_BITS) - 1;
    localparam int HALF_FULL = FULL / 2;
    // floor(2^(2*CB) / FULL); low by at most one after the shift
    localparam int RECIP_FULL = (1 << CHANNEL_BITS) + 1;

    // Hue geometry
    localparam int SECT_DEG = 60;
    localparam logic [HUE_W-1:0] HUE_TURN = HUE_W'(360);

    // Secondary term: chroma * frac / 60 through a scaled reciprocal
    localparam int XNUM_W     = CHANNEL_BITS + FRAC_W;
    localparam int X_SHIFT    = XNUM_W;
    localparam int RECIP_SECT = (1 << X_SHIFT) / SECT_DEG;
    localparam int XPROD_W    = XNUM_W + CHANNEL_BITS + 1;

    // Hue sector codes
    localparam logic [SECT_W-1:0] SECT_RED_YEL   = 3'd0;
    localparam logic [SECT_W-1:0] SECT_YEL_GRN   = 3'd1;
    localparam logic [SECT_W-1:0] SECT_GRN_CYN   = 3'd2;
    localparam logic [SECT_W-1:0] SECT_CYN_BLU   = 3'd3;
    localparam logic [SECT_W-1:0] SECT_BLU_MAG   = 3'd4;
    localparam logic [SECT_W-1:0] SECT_MAG_RED   = 3'd5;
    // Raw decode of a hue of exactly one full turn
    localparam logic [SECT_W-1:0] SECT_FULL_TURN = 3'd6;

    // Input item
    typedef struct packed {
        logic [HUE_W-1:0]        hue_deg;
        logic [CHANNEL_BITS-1:0] saturation;
        logic [CHANNEL_BITS-1:0] brightness;
    } hsvrgb_in_t;

    // Result item
    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } hsvrgb_out_t;

    // Hue stage to chroma stages
    typedef struct packed {
        logic [SECT_W-1:0]       sector;
        logic [FRAC_W-1:0]       frac;
        logic [CHANNEL_BITS-1:0] val;
        logic [PROD_W-1:0]       prod;
    } hsvrgb_hue_t;

    // Chroma stages to mix stages
    typedef struct packed {
        logic [SECT_W-1:0]       sector;
        logic [FRAC_W-1:0]       frac;
        logic [CHANNEL_BITS-1:0] chroma;
        logic [CHANNEL_BITS-1:0] base;
    } hsvrgb_chroma_t;

endpackage

`default_nettype wire

@@ sv/hsvrgb_hue.sv @@
// ============================================================================
// hsvrgb_hue
// First stage: hue wrap, sector decode, sector fraction and the S*V product.
// ============================================================================
`default_nettype none

module hsvrgb_hue
    import hsvrgb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire hsvrgb_in_t  in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output hsvrgb_hue_t      out_data
);

    logic [HUE_W-1:0]  hue_w;
    logic [SECT_W-1:0] raw_sect;
    logic [HUE_W-1:0]  hue_rem;
    logic [FRAC_W-1:0] mod_sect;
    hsvrgb_hue_t       stage_next;
    hsvrgb_hue_t       stage_reg;
    logic              valid_reg;

    // Hue decode: wrap above a full turn, then find the 60-degree sector
    always_comb begin
        hue_w = (in_data.hue_deg > HUE_TURN) ? in_data.hue_deg - HUE_TURN
                                             : in_data.hue_deg;
        if (hue_w < HUE_W'(SECT_DEG)) begin
            raw_sect = SECT_RED_YEL;
        end else if (hue_w < HUE_W'(2 * SECT_DEG)) begin
            raw_sect = SECT_YEL_GRN;
        end else if (hue_w < HUE_W'(3 * SECT_DEG)) begin
            raw_sect = SECT_GRN_CYN;
        end else if (hue_w < HUE_W'(4 * SECT_DEG)) begin
            raw_sect = SECT_CYN_BLU;
        end else if (hue_w < HUE_W'(5 * SECT_DEG)) begin
            raw_sect = SECT_BLU_MAG;
        end else if (hue_w < HUE_W'(6 * SECT_DEG)) begin
            raw_sect = SECT_MAG_RED;
        end else begin
            raw_sect = SECT_FULL_TURN;
        end
        hue_rem  = hue_w - HUE_W'(raw_sect) * HUE_W'(SECT_DEG);
        mod_sect = hue_rem[FRAC_W-1:0];

        // Odd sectors fall off from the peak, even sectors rise to it
        stage_next.frac   = raw_sect[0] ? FRAC_W'(SECT_DEG) - mod_sect : mod_sect;
        // A full turn lands in the last sector with zero fraction
        stage_next.sector = (raw_sect > SECT_MAG_RED) ? SECT_MAG_RED : raw_sect;
        stage_next.val    = in_data.brightness;
        stage_next.prod   = PROD_W'(in_data.saturation) * PROD_W'(in_data.brightness);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = stage_reg;

    // Stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            stage_reg <= stage_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/hsvrgb_chroma.sv @@
// ============================================================================
// hsvrgb_chroma
// Two stages: rounded chroma = (S*V + FULL/2) / FULL by a reciprocal multiply
// with one correction step, then the offset m = V - C.
// ============================================================================
`default_nettype none

module hsvrgb_chroma
    import hsvrgb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire hsvrgb_hue_t in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output hsvrgb_chroma_t   out_data
);

    localparam int QPROD_W = 3 * CHANNEL_BITS + 1;

    typedef struct packed {
        logic [SECT_W-1:0]       sector;
        logic [FRAC_W-1:0]       frac;
        logic [CHANNEL_BITS-1:0] val;
        logic [PROD_W-1:0]       num;
        logic [CHANNEL_BITS-1:0] quot;
    } quot_stage_t;

    logic [PROD_W-1:0]       num;
    logic [QPROD_W-1:0]      qprod;
    quot_stage_t             quot_next;
    quot_stage_t             quot_reg;
    logic                    quot_valid_reg;
    logic                    quot_ready;

    logic [PROD_W-1:0]       rem;
    logic [CHANNEL_BITS-1:0] chroma;
    hsvrgb_chroma_t          chroma_next;
    hsvrgb_chroma_t          chroma_reg;
    logic                    chroma_valid_reg;
    logic                    chroma_ready;

    // Estimate quotient; it is exact or one low
    always_comb begin
        num   = in_data.prod + PROD_W'(HALF_FULL);
        qprod = QPROD_W'(num) * QPROD_W'(RECIP_FULL);
        quot_next.sector = in_data.sector;
        quot_next.frac   = in_data.frac;
        quot_next.val    = in_data.val;
        quot_next.num    = num;
        quot_next.quot   = qprod[3*CHANNEL_BITS-1:2*CHANNEL_BITS];
    end

    // Correct the estimate and form the offset
    always_comb begin
        rem    = quot_reg.num - PROD_W'(quot_reg.quot) * PROD_W'(FULL);
        chroma = quot_reg.quot + CHANNEL_BITS'(rem >= PROD_W'(FULL));
        chroma_next.sector = quot_reg.sector;
        chroma_next.frac   = quot_reg.frac;
        chroma_next.chroma = chroma;
        chroma_next.base   = quot_reg.val - chroma;
    end

    assign chroma_ready = !chroma_valid_reg || out_ready;
    assign quot_ready   = !quot_valid_reg || chroma_ready;
    assign in_ready     = quot_ready;
    assign out_valid    = chroma_valid_reg;
    assign out_data     = chroma_reg;

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            quot_valid_reg   <= 1'b0;
            chroma_valid_reg <= 1'b0;
        end else begin
            if (quot_ready) begin
                quot_valid_reg <= in_valid;
            end
            if (chroma_ready) begin
                chroma_valid_reg <= quot_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (quot_ready && in_valid) begin
            quot_reg <= quot_next;
        end
        if (chroma_ready && quot_valid_reg) begin
            chroma_reg <= chroma_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/hsvrgb_mix.sv @@
// ============================================================================
// hsvrgb_mix
// Two stages: rounded X = (C*frac + 30) / 60 by a reciprocal multiply with
// one correction, then sector placement of C, X, 0 plus the offset m.
// ============================================================================
`default_nettype none

module hsvrgb_mix
    import hsvrgb_pkg::*;
(
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire hsvrgb_chroma_t in_data,
    output logic                out_valid,
    input  wire logic           out_ready,
    output hsvrgb_out_t         out_data
);

    typedef struct packed {
        logic [SECT_W-1:0]       sector;
        logic [CHANNEL_BITS-1:0] chroma;
        logic [CHANNEL_BITS-1:0] base;
        logic [XNUM_W-1:0]       num;
        logic [CHANNEL_BITS-1:0] quot;
    } xq_stage_t;

    logic [XNUM_W-1:0]       num;
    logic [XPROD_W-1:0]      qprod;
    xq_stage_t               xq_next;
    xq_stage_t               xq_reg;
    logic                    xq_valid_reg;
    logic                    xq_ready;

    logic [XNUM_W-1:0]       rem;
    logic [CHANNEL_BITS-1:0] xval;
    logic [CHANNEL_BITS-1:0] r_raw;
    logic [CHANNEL_BITS-1:0] g_raw;
    logic [CHANNEL_BITS-1:0] b_raw;
    hsvrgb_out_t             rgb_next;
    hsvrgb_out_t             rgb_reg;
    logic                    rgb_valid_reg;
    logic                    rgb_ready;

    // Estimate X; exact or one low
    always_comb begin
        num   = XNUM_W'(in_data.chroma) * XNUM_W'(in_data.frac) + XNUM_W'(SECT_DEG / 2);
        qprod = XPROD_W'(num) * XPROD_W'(RECIP_SECT);
        xq_next.sector = in_data.sector;
        xq_next.chroma = in_data.chroma;
        xq_next.base   = in_data.base;
        xq_next.num    = num;
        xq_next.quot   = qprod[X_SHIFT+CHANNEL_BITS-1:X_SHIFT];
    end

    // Correct X, place the terms by sector, add the offset
    always_comb begin
        rem  = xq_reg.num - XNUM_W'(xq_reg.quot) * XNUM_W'(SECT_DEG);
        xval = xq_reg.quot + CHANNEL_BITS'(rem >= XNUM_W'(SECT_DEG));
        unique case (xq_reg.sector)
            SECT_RED_YEL: begin
                r_raw = xq_reg.chroma; g_raw = xval;          b_raw = '0;
            end
            SECT_YEL_GRN: begin
                r_raw = xval;          g_raw = xq_reg.chroma; b_raw = '0;
            end
            SECT_GRN_CYN: begin
                r_raw = '0;            g_raw = xq_reg.chroma; b_raw = xval;
            end
            SECT_CYN_BLU: begin
                r_raw = '0;            g_raw = xval;          b_raw = xq_reg.chroma;
            end
            SECT_BLU_MAG: begin
                r_raw = xval;          g_raw = '0;            b_raw = xq_reg.chroma;
            end
            default: begin
                r_raw = xq_reg.chroma; g_raw = '0;            b_raw = xval;
            end
        endcase
        // Sums never pass V, so no carry is lost
        rgb_next.red   = r_raw + xq_reg.base;
        rgb_next.green = g_raw + xq_reg.base;
        rgb_next.blue  = b_raw + xq_reg.base;
    end

    assign rgb_ready = !rgb_valid_reg || out_ready;
    assign xq_ready  = !xq_valid_reg || rgb_ready;
    assign in_ready  = xq_ready;
    assign out_valid = rgb_valid_reg;
    assign out_data  = rgb_reg;

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            xq_valid_reg  <= 1'b0;
            rgb_valid_reg <= 1'b0;
        end else begin
            if (xq_ready) begin
                xq_valid_reg <= in_valid;
            end
            if (rgb_ready) begin
                rgb_valid_reg <= xq_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (xq_ready && in_valid) begin
            xq_reg <= xq_next;
        end
        if (rgb_ready && xq_valid_reg) begin
            rgb_reg <= rgb_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/hsv_to_rgb_color_unit.sv @@
// ============================================================================
// hsv_to_rgb_color_unit
// HSV to RGB conversion, five register stages, one item per clock while the output is not stalled.
// ============================================================================
// Usage:
//   s_valid/s_ready/s_data take one HSV item: hue in whole degrees 0..360
//   (360 acts as 0, larger codes wrap by one turn), saturation and
//   brightness as fractions of 255. m_valid/m_ready/m_data deliver one RGB
//   item per input item, in order.
//   Stages, each registered and in this order: hue decode and S*V,
//   chroma quotient estimate, chroma correction, X estimate, then X
//   correction with sector placement into the output register.
//   Throughput is one item per cycle while m_ready stays high; each stage
//   has its own valid bit and moves whenever the stage after it is empty or
//   moving, so bubbles close up while the output is stalled.
//   When the receiver holds m_ready low the result stays in the output
//   register and the stages behind it fill; s_ready drops only when all
//   five hold an item.
//   Reset (aresetn low, synchronous) empties every stage; there is no
//   other state.
// ============================================================================
`default_nettype none

module hsv_to_rgb_color_unit
    import hsvrgb_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire hsvrgb_in_t  s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output hsvrgb_out_t      m_data
);

    logic           hue_valid;
    logic           hue_ready;
    hsvrgb_hue_t    hue_data;
    logic           chroma_valid;
    logic           chroma_ready;
    hsvrgb_chroma_t chroma_data;

    // Hue decode and S*V product
    hsvrgb_hue u_hue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_data   (s_data),
        .out_valid (hue_valid),
        .out_ready (hue_ready),
        .out_data  (hue_data)
    );

    // Chroma and offset
    hsvrgb_chroma u_chroma (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (hue_valid),
        .in_ready  (hue_ready),
        .in_data   (hue_data),
        .out_valid (chroma_valid),
        .out_ready (chroma_ready),
        .out_data  (chroma_data)
    );

    // Secondary term and channel placement
    hsvrgb_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chroma_valid),
        .in_ready  (chroma_ready),
        .in_data   (chroma_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

    // Reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A draining output must keep every stage moving
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while output drains");

    // An accepted item is offered at the output once it has passed every stage while m_ready stays high
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) ##1 m_ready ##1 m_ready ##1 m_ready ##1 m_ready
        |=> m_valid)
        else $error("item missing at the output after pipeline latency");

    // Internal hops never stall while the output drains
    a_inner_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> (hue_ready && chroma_ready))
        else $error("internal stage stalled while output drains");

endmodule

`default_nettype wire

@@ bench/hsv_to_rgb_color_unit_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// hsv_to_rgb_color_unit_test
// Self-checking bench for the HSV to RGB color unit. A queue of HSV items
// (directed corner colors, then random ones) feeds a valid/ready driver. Each
// accepted item is converted by an in-bench integer model. The expected RGB
// is queued and compared field by field with every result the unit delivers.
// Both sides stall at random, except during one calm stretch.
// ============================================================================
module hsv_to_rgb_color_unit_test;
    import hsvrgb_pkg::*;

    localparam int RANDOM_COLORS = 1200;
    localparam int STALL_LIMIT   = 20000;   // cycles with no handshake on either side
    localparam int DRAIN_CYCLES  = 20;      // pipeline is five stages deep
    localparam int CALM_FIRST    = 500;     // no idling for items in this window
    localparam int CALM_LAST     = 700;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    hsvrgb_in_t  s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    hsvrgb_out_t m_data;

    hsvrgb_in_t  hsv_pending[$];    // colors not yet offered to the unit
    hsvrgb_out_t rgb_expected[$];   // converted colors still to come out
    int          colors_sent    = 0;
    int          colors_checked = 0;
    int          mismatches     = 0;
    int          stall_cycles   = 0;
    int          wrapped_hues   = 0;
    bit [6:0]    sectors_hit    = '0;  // bit 6 marks a hue of exactly 360

    hsv_to_rgb_color_unit DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Hue codes above one turn wrap back by 360 degrees
    function automatic logic [HUE_W-1:0] hue_in_turn(logic [HUE_W-1:0] hue);
        return (hue > HUE_TURN) ? hue - HUE_TURN : hue;
    endfunction

    // Integer HSV to RGB conversion with half-up rounding
    function automatic hsvrgb_out_t hsv_color_to_rgb(hsvrgb_in_t hsv);
        logic [HUE_W-1:0]  hue;
        logic [SECT_W-1:0] sector;
        int unsigned       sat, val, chroma, xterm, base, hue_mod, frac;
        int unsigned       r, g, b;
        hsvrgb_out_t       rgb;
        hue     = hue_in_turn(hsv.hue_deg);
        sat     = hsv.saturation;
        val     = hsv.brightness;
        chroma  = (sat * val + FULL / 2) / FULL;
        hue_mod = hue % (2 * SECT_DEG);
        frac    = SECT_DEG - ((hue_mod >= SECT_DEG) ? hue_mod - SECT_DEG
                                                     : SECT_DEG - hue_mod);
        xterm   = (chroma * frac + SECT_DEG / 2) / SECT_DEG;
        base    = val - chroma;
        sector  = SECT_W'(hue / SECT_DEG);
        case (sector)
            SECT_RED_YEL: begin r = chroma; g = xterm;  b = 0;      end
            SECT_YEL_GRN: begin r = xterm;  g = chroma; b = 0;      end
            SECT_GRN_CYN: begin r = 0;      g = chroma; b = xterm;  end
            SECT_CYN_BLU: begin r = 0;      g = xterm;  b = chroma; end
            SECT_BLU_MAG: begin r = xterm;  g = 0;      b = chroma; end
            // last sector, and hue 360 which lands one past it
            default:      begin r = chroma; g = 0;      b = xterm;  end
        endcase
        rgb.red   = CHANNEL_BITS'(r + base);
        rgb.green = CHANNEL_BITS'(g + base);
        rgb.blue  = CHANNEL_BITS'(b + base);
        return rgb;
    endfunction

    task automatic add_color(int hue, int sat, int val);
        hsvrgb_in_t item;
        item.hue_deg    = HUE_W'(hue);
        item.saturation = CHANNEL_BITS'(sat);
        item.brightness = CHANNEL_BITS'(val);
        hsv_pending.push_back(item);
    endtask

    // Mostly random channel values, with the extremes drawn often
    function automatic int pick_channel();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 0;
        if (roll == 1) return FULL;
        return $urandom_range(0, FULL);
    endfunction

    // Driver: valid holds with its item until the handshake
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                rgb_expected.push_back(hsv_color_to_rgb(s_data));
                sectors_hit[hue_in_turn(s_data.hue_deg) / SECT_DEG] = 1'b1;
                if (s_data.hue_deg > HUE_TURN) wrapped_hues++;
                colors_sent++;
            end
            if (!s_valid || s_ready) begin
                if (hsv_pending.size() > 0 &&
                    ((colors_sent >= CALM_FIRST && colors_sent < CALM_LAST) ||
                     $urandom_range(0, 99) >= 25)) begin
                    s_valid <= 1'b1;
                    s_data  <= hsv_pending.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result against the oldest expected color
    always @(posedge aclk) begin : result_check
        hsvrgb_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (rgb_expected.size() == 0) begin
                    $error("unexpected result: red %0d green %0d blue %0d",
                           m_data.red, m_data.green, m_data.blue);
                    mismatches++;
                end else begin
                    want = rgb_expected.pop_front();
                    if (m_data.red !== want.red) begin
                        $error("red: expected %0d, got %0d", want.red, m_data.red);
                        mismatches++;
                    end
                    if (m_data.green !== want.green) begin
                        $error("green: expected %0d, got %0d", want.green, m_data.green);
                        mismatches++;
                    end
                    if (m_data.blue !== want.blue) begin
                        $error("blue: expected %0d, got %0d", want.blue, m_data.blue);
                        mismatches++;
                    end
                end
                colors_checked++;
            end
            m_ready <= (colors_checked >= CALM_FIRST && colors_checked < CALM_LAST) ||
                       ($urandom_range(0, 99) >= 25);
        end
    end

    // Watchdog: cycles since the last handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Stimulus, reset and end of run
    initial begin
        // sector edges at full color, plus hue 360 and wrapped hue codes
        add_color(0,   FULL, FULL);
        add_color(1,   FULL, FULL);
        add_color(59,  FULL, FULL);
        add_color(60,  FULL, FULL);
        add_color(61,  FULL, FULL);
        add_color(119, FULL, FULL);
        add_color(120, FULL, FULL);
        add_color(180, FULL, FULL);
        add_color(239, FULL, FULL);
        add_color(240, FULL, FULL);
        add_color(300, FULL, FULL);
        add_color(359, FULL, FULL);
        add_color(360, FULL, FULL);
        add_color(361, FULL, FULL);
        add_color(511, FULL, FULL);
        // gray, black, dim and mid-scale rounding cases
        add_color(200, 0,    FULL);
        add_color(90,  FULL, 0);
        add_color(30,  128,  200);
        add_color(150, 1,    1);
        add_color(270, FULL, 1);
        add_color(330, 127,  128);
        add_color(45,  0,    0);
        for (int i = 0; i < RANDOM_COLORS; i++) begin
            if ($urandom_range(0, 99) < 15)
                add_color($urandom_range(361, 511), pick_channel(), pick_channel());
            else
                add_color($urandom_range(0, 360), pick_channel(), pick_channel());
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (!(hsv_pending.size() == 0 && !s_valid && rgb_expected.size() == 0) &&
               stall_cycles < STALL_LIMIT)
            @(posedge aclk);

        if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout: %0d colors still expected", rgb_expected.size());
            $display("SCOREBOARD MISMATCH");
        end else begin
            repeat (DRAIN_CYCLES) @(posedge aclk);
            if (rgb_expected.size() != 0) begin
                $error("%0d expected colors never came out", rgb_expected.size());
                mismatches++;
            end
            $display("converted %0d colors, %0d checked, %0d with hue codes above 360",
                     colors_sent, colors_checked, wrapped_hues);
            $display("hue sectors reached: %b (bit 6 is hue 360)", sectors_hit);
            if (mismatches == 0)
                $display("SCOREBOARD CLEAN");
            else
                $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
